// ===== src/bgpc_pkg.sv =====
// Package for the binocular gaze pursuit controller: field widths, mode limits,
// register indexes and the microcode program of the shared multiply-accumulate sequencer.
// No dependencies.
package bgpc_pkg;

    localparam int ANGLE_W = 16;
    localparam int GAIN_W  = 18;
    localparam int ERR_W   = 17;
    localparam int DERR_W  = 18;
    localparam int INTEG_W = 32;
    localparam int OPND_W  = 33;
    localparam int PROD_W  = GAIN_W + OPND_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int GAIN_FRAC = 10;
    localparam int RND_W   = ACC_W - GAIN_FRAC;
    localparam int SUM_W   = RND_W + 1;
    localparam int STEP_W  = 5;

    // Mode switching limits on |target - axis| (Q4.13)
    localparam logic signed [ERR_W-1:0] NEAR_LIMIT = 17'sd715;
    localparam logic signed [ERR_W-1:0] FAR_LIMIT  = 17'sd1429;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_GAIN_S_DT  = 3'd0;
    localparam logic [2:0] REG_GAIN_N     = 3'd1;
    localparam logic [2:0] REG_GAIN_K_DT  = 3'd2;
    localparam logic [2:0] REG_GAIN_H     = 3'd3;
    localparam logic [2:0] REG_GAIN_A1_DT = 3'd4;
    localparam logic [2:0] REG_GAIN_R1    = 3'd5;
    localparam logic [2:0] REG_GAIN_R2    = 3'd6;

    typedef enum logic [2:0] {
        G_S, G_N, G_K, G_H, G_A1, G_R1, G_R2
    } gsel_t;

    typedef enum logic [2:0] {
        O_RATE, O_EL, O_DL, O_ER, O_DR, O_IL, O_IR
    } osel_t;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_LOAD, ACC_LOADN, ACC_ADD, ACC_SUB
    } acc_op_t;

    typedef enum logic [2:0] {
        WB_NONE, WB_IL, WB_IR, WB_YL, WB_YR
    } wb_t;

    typedef enum logic [1:0] {
        FL_NEXT, FL_DECIDE, FL_EMIT
    } flow_t;

    typedef struct packed {
        gsel_t              gsel;
        osel_t              osel;
        acc_op_t            acc_op;
        wb_t                wb;
        flow_t              flow;
        logic [STEP_W-1:0]  target;
    } ucode_t;

    localparam logic [STEP_W-1:0] STEP_EMIT = 5'd18;

    // Step k multiplies for step k+1; step k accumulates the product of step k-1.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc = '{gsel: G_S, osel: O_EL, acc_op: ACC_HOLD, wb: WB_NONE,
               flow: FL_NEXT, target: STEP_EMIT};
        case (step)
            5'd0:  uc.flow = FL_DECIDE;
            5'd1:  begin uc.gsel = G_A1; uc.osel = O_RATE; end
            5'd2:  begin uc.gsel = G_S;  uc.osel = O_EL;   uc.acc_op = ACC_LOAD; end
            5'd3:  begin uc.gsel = G_N;  uc.osel = O_DL;   uc.acc_op = ACC_SUB;  end
            5'd4:  begin uc.gsel = G_K;  uc.osel = O_ER;   uc.acc_op = ACC_SUB;  end
            5'd5:  begin uc.gsel = G_H;  uc.osel = O_DR;   uc.acc_op = ACC_SUB;  end
            5'd6:  begin uc.gsel = G_A1; uc.osel = O_RATE; uc.acc_op = ACC_SUB;  end
            5'd7:  begin
                uc.gsel = G_S; uc.osel = O_ER; uc.acc_op = ACC_LOADN; uc.wb = WB_IL;
            end
            5'd8:  begin uc.gsel = G_N;  uc.osel = O_DR;   uc.acc_op = ACC_ADD;  end
            5'd9:  begin uc.gsel = G_K;  uc.osel = O_EL;   uc.acc_op = ACC_ADD;  end
            5'd10: begin uc.gsel = G_H;  uc.osel = O_DL;   uc.acc_op = ACC_ADD;  end
            5'd11: uc.acc_op = ACC_ADD;
            5'd12: begin uc.gsel = G_R1; uc.osel = O_IL;   uc.wb = WB_IR;        end
            5'd13: begin uc.gsel = G_R2; uc.osel = O_IR;   uc.acc_op = ACC_LOADN; end
            5'd14: begin uc.gsel = G_R1; uc.osel = O_IR;   uc.acc_op = ACC_ADD;  end
            5'd15: begin
                uc.gsel = G_R2; uc.osel = O_IL; uc.acc_op = ACC_LOAD; uc.wb = WB_YL;
            end
            5'd16: uc.acc_op = ACC_SUB;
            5'd17: uc.wb = WB_YR;
            5'd18: uc.flow = FL_EMIT;
            default: uc.flow = FL_EMIT;
        endcase
        return uc;
    endfunction

endpackage

// ===== src/binocular_gaze_pursuit_controller.sv =====
// Binocular gaze pursuit controller top level: APB gain registers, input word capture,
// microcoded sequencer over one shared 18x33 multiplier, and the output register.
// Depends on bgpc_pkg.
//
// A pursuit word runs the 19-step program (decide, seventeen multiply, accumulate and
// write-back steps, emit) around the single multiplier; a saccade word jumps from the
// decide step straight to the emit step, which holds until the output register is free.
// A new word is taken only once the previous result sits in the output register.
// Reset (aresetn low, synchronous): gains, mode, integrators, previous errors and yaw states clear.
module binocular_gaze_pursuit_controller (
    input  logic          aclk,
    input  logic          aresetn,
    // tdata fields, low bit up: target_left_horiz, target_right_horiz, target_left_vert,
    // target_right_vert, axis_left_horiz, axis_right_horiz, axis_left_vert,
    // axis_right_vert, head_rate_horiz (16 bits each)
    input  logic [143:0]  s_axis_tdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata fields, low bit up: left_vert_cmd, left_horiz_cmd, right_vert_cmd,
    // right_horiz_cmd (16 bits each)
    output logic [63:0]   m_axis_tdata,
    // tuser fields, low bit up: in_pursuit
    output logic          m_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int AW = bgpc_pkg::ANGLE_W;
    localparam int GW = bgpc_pkg::GAIN_W;
    localparam int EW = bgpc_pkg::ERR_W;
    localparam int DW = bgpc_pkg::DERR_W;
    localparam int IW = bgpc_pkg::INTEG_W;
    localparam int OW = bgpc_pkg::OPND_W;
    localparam int PW = bgpc_pkg::PROD_W;
    localparam int CW = bgpc_pkg::ACC_W;
    localparam int RW = bgpc_pkg::RND_W;
    localparam int SW = bgpc_pkg::SUM_W;
    localparam int TW = bgpc_pkg::STEP_W;

    // Saturation bounds at the write-back width
    localparam logic signed [SW-1:0] INTEG_HI = $signed((SW)'({1'b0, {(IW-1){1'b1}}}));
    localparam logic signed [SW-1:0] INTEG_LO = -INTEG_HI - (SW)'(1);
    localparam logic signed [SW-1:0] ANGLE_HI = $signed((SW)'({1'b0, {(AW-1){1'b1}}}));
    localparam logic signed [SW-1:0] ANGLE_LO = -ANGLE_HI - (SW)'(1);

    // Gain registers, one per configuration register
    logic signed [GW-1:0] g_s_reg,  g_s_next;
    logic signed [GW-1:0] g_n_reg,  g_n_next;
    logic signed [GW-1:0] g_k_reg,  g_k_next;
    logic signed [GW-1:0] g_h_reg,  g_h_next;
    logic signed [GW-1:0] g_a1_reg, g_a1_next;
    logic signed [GW-1:0] g_r1_reg, g_r1_next;
    logic signed [GW-1:0] g_r2_reg, g_r2_next;

    // Captured input word
    logic [143:0] in_reg, in_next;

    // Controller state
    logic                 mode_reg, mode_next;
    logic signed [EW-1:0] prev_l_reg, prev_l_next;
    logic signed [EW-1:0] prev_r_reg, prev_r_next;
    logic signed [IW-1:0] integ_l_reg, integ_l_next;
    logic signed [IW-1:0] integ_r_reg, integ_r_next;
    logic signed [AW-1:0] yaw_l_reg, yaw_l_next;
    logic signed [AW-1:0] yaw_r_reg, yaw_r_next;

    // Per-word working values
    logic signed [EW-1:0] el_reg, el_next;
    logic signed [EW-1:0] er_reg, er_next;
    logic signed [DW-1:0] dl_reg, dl_next;
    logic signed [DW-1:0] dr_reg, dr_next;

    // Datapath
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [CW-1:0] acc_reg, acc_next;

    // Sequencer
    logic           busy_reg, busy_next;
    logic [TW-1:0]  step_reg, step_next;

    // Output register
    logic           m_valid_reg, m_valid_next;
    logic [63:0]    m_data_reg, m_data_next;
    logic           m_user_reg, m_user_next;

    bgpc_pkg::ucode_t uc;

    logic signed [AW-1:0] tlh, trh, tlv, trv, alh, arh, alv, arv, rate;
    logic signed [EW-1:0] e0, e1, e2, e3, el_c, er_c;
    logic signed [DW-1:0] dl_c, dr_c;
    logic                 all_near, any_far, pursue;
    logic signed [GW-1:0] gain_mux;
    logic signed [OW-1:0] opnd_mux;
    logic signed [CW-1:0] prod_ext, acc_rnd;
    logic signed [RW-1:0] rnd;
    logic signed [SW-1:0] wb_base, wb_sum;
    logic signed [IW-1:0] wb_integ;
    logic signed [AW-1:0] wb_yaw;
    logic                 cfg_wr, in_acc, out_free;

    assign tlh  = in_reg[15:0];
    assign trh  = in_reg[31:16];
    assign tlv  = in_reg[47:32];
    assign trv  = in_reg[63:48];
    assign alh  = in_reg[79:64];
    assign arh  = in_reg[95:80];
    assign alv  = in_reg[111:96];
    assign arv  = in_reg[127:112];
    assign rate = in_reg[143:128];

    assign uc = bgpc_pkg::ucode_rom(step_reg);

    // Gaze errors against the measured axes pick the mode
    assign e0 = {tlh[AW-1], tlh} - {alh[AW-1], alh};
    assign e1 = {trh[AW-1], trh} - {arh[AW-1], arh};
    assign e2 = {tlv[AW-1], tlv} - {alv[AW-1], alv};
    assign e3 = {trv[AW-1], trv} - {arv[AW-1], arv};

    assign all_near = (e0 < bgpc_pkg::NEAR_LIMIT) && (e0 > -bgpc_pkg::NEAR_LIMIT)
                   && (e1 < bgpc_pkg::NEAR_LIMIT) && (e1 > -bgpc_pkg::NEAR_LIMIT)
                   && (e2 < bgpc_pkg::NEAR_LIMIT) && (e2 > -bgpc_pkg::NEAR_LIMIT)
                   && (e3 < bgpc_pkg::NEAR_LIMIT) && (e3 > -bgpc_pkg::NEAR_LIMIT);
    assign any_far  = (e0 > bgpc_pkg::FAR_LIMIT) || (e0 < -bgpc_pkg::FAR_LIMIT)
                   || (e1 > bgpc_pkg::FAR_LIMIT) || (e1 < -bgpc_pkg::FAR_LIMIT)
                   || (e2 > bgpc_pkg::FAR_LIMIT) || (e2 < -bgpc_pkg::FAR_LIMIT)
                   || (e3 > bgpc_pkg::FAR_LIMIT) || (e3 < -bgpc_pkg::FAR_LIMIT);
    assign pursue   = mode_reg ? !any_far : all_near;

    // Pursuit errors against the controller's own yaw state
    assign el_c = {tlh[AW-1], tlh} - {yaw_l_reg[AW-1], yaw_l_reg};
    assign er_c = {trh[AW-1], trh} - {yaw_r_reg[AW-1], yaw_r_reg};
    assign dl_c = {el_c[EW-1], el_c} - {prev_l_reg[EW-1], prev_l_reg};
    assign dr_c = {er_c[EW-1], er_c} - {prev_r_reg[EW-1], prev_r_reg};

    // Multiplier operand selection
    always_comb begin
        case (uc.gsel)
            bgpc_pkg::G_S:  gain_mux = g_s_reg;
            bgpc_pkg::G_N:  gain_mux = g_n_reg;
            bgpc_pkg::G_K:  gain_mux = g_k_reg;
            bgpc_pkg::G_H:  gain_mux = g_h_reg;
            bgpc_pkg::G_A1: gain_mux = g_a1_reg;
            bgpc_pkg::G_R1: gain_mux = g_r1_reg;
            bgpc_pkg::G_R2: gain_mux = g_r2_reg;
            default:        gain_mux = '0;
        endcase
        case (uc.osel)
            bgpc_pkg::O_RATE: opnd_mux = {{(OW-AW){rate[AW-1]}}, rate};
            bgpc_pkg::O_EL:   opnd_mux = {{(OW-EW){el_reg[EW-1]}}, el_reg};
            bgpc_pkg::O_DL:   opnd_mux = {{(OW-DW){dl_reg[DW-1]}}, dl_reg};
            bgpc_pkg::O_ER:   opnd_mux = {{(OW-EW){er_reg[EW-1]}}, er_reg};
            bgpc_pkg::O_DR:   opnd_mux = {{(OW-DW){dr_reg[DW-1]}}, dr_reg};
            bgpc_pkg::O_IL:   opnd_mux = {{(OW-IW){integ_l_reg[IW-1]}}, integ_l_reg};
            bgpc_pkg::O_IR:   opnd_mux = {{(OW-IW){integ_r_reg[IW-1]}}, integ_r_reg};
            default:          opnd_mux = '0;
        endcase
    end

    assign prod_next = gain_mux * opnd_mux;
    assign prod_ext  = {{(CW-PW){prod_reg[PW-1]}}, prod_reg};

    // Round the accumulator back to Q.13: floor((acc + half) / 1024)
    assign acc_rnd = acc_reg + (CW)'(1 << (bgpc_pkg::GAIN_FRAC - 1));
    assign rnd     = acc_rnd[CW-1:bgpc_pkg::GAIN_FRAC];

    always_comb begin
        case (uc.wb)
            bgpc_pkg::WB_IL: wb_base = {{(SW-IW){integ_l_reg[IW-1]}}, integ_l_reg};
            bgpc_pkg::WB_IR: wb_base = {{(SW-IW){integ_r_reg[IW-1]}}, integ_r_reg};
            bgpc_pkg::WB_YL: wb_base = {{(SW-AW){yaw_l_reg[AW-1]}}, yaw_l_reg};
            bgpc_pkg::WB_YR: wb_base = {{(SW-AW){yaw_r_reg[AW-1]}}, yaw_r_reg};
            default:         wb_base = '0;
        endcase
    end

    assign wb_sum = wb_base + {rnd[RW-1], rnd};

    // Saturate the written value to the integrator or the angle range
    always_comb begin
        if (wb_sum > INTEG_HI) begin
            wb_integ = INTEG_HI[IW-1:0];
        end else if (wb_sum < INTEG_LO) begin
            wb_integ = INTEG_LO[IW-1:0];
        end else begin
            wb_integ = wb_sum[IW-1:0];
        end
        if (wb_sum > ANGLE_HI) begin
            wb_yaw = ANGLE_HI[AW-1:0];
        end else if (wb_sum < ANGLE_LO) begin
            wb_yaw = ANGLE_LO[AW-1:0];
        end else begin
            wb_yaw = wb_sum[AW-1:0];
        end
    end

    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    // Register read-back
    always_comb begin
        case (paddr[4:2])
            bgpc_pkg::REG_GAIN_S_DT:  prdata = {{(32-GW){g_s_reg[GW-1]}}, g_s_reg};
            bgpc_pkg::REG_GAIN_N:     prdata = {{(32-GW){g_n_reg[GW-1]}}, g_n_reg};
            bgpc_pkg::REG_GAIN_K_DT:  prdata = {{(32-GW){g_k_reg[GW-1]}}, g_k_reg};
            bgpc_pkg::REG_GAIN_H:     prdata = {{(32-GW){g_h_reg[GW-1]}}, g_h_reg};
            bgpc_pkg::REG_GAIN_A1_DT: prdata = {{(32-GW){g_a1_reg[GW-1]}}, g_a1_reg};
            bgpc_pkg::REG_GAIN_R1:    prdata = {{(32-GW){g_r1_reg[GW-1]}}, g_r1_reg};
            bgpc_pkg::REG_GAIN_R2:    prdata = {{(32-GW){g_r2_reg[GW-1]}}, g_r2_reg};
            default:                  prdata = '0;
        endcase
    end

    assign pready        = 1'b1;
    assign s_axis_tready = !busy_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    always_comb begin
        g_s_next  = g_s_reg;
        g_n_next  = g_n_reg;
        g_k_next  = g_k_reg;
        g_h_next  = g_h_reg;
        g_a1_next = g_a1_reg;
        g_r1_next = g_r1_reg;
        g_r2_next = g_r2_reg;
        in_next      = in_reg;
        mode_next    = mode_reg;
        prev_l_next  = prev_l_reg;
        prev_r_next  = prev_r_reg;
        integ_l_next = integ_l_reg;
        integ_r_next = integ_r_reg;
        yaw_l_next   = yaw_l_reg;
        yaw_r_next   = yaw_r_reg;
        el_next      = el_reg;
        er_next      = er_reg;
        dl_next      = dl_reg;
        dr_next      = dr_reg;
        acc_next     = acc_reg;
        busy_next    = busy_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        // Write a gain; indexes beyond the list drop the word
        if (cfg_wr) begin
            case (paddr[4:2])
                bgpc_pkg::REG_GAIN_S_DT:  g_s_next  = pwdata[GW-1:0];
                bgpc_pkg::REG_GAIN_N:     g_n_next  = pwdata[GW-1:0];
                bgpc_pkg::REG_GAIN_K_DT:  g_k_next  = pwdata[GW-1:0];
                bgpc_pkg::REG_GAIN_H:     g_h_next  = pwdata[GW-1:0];
                bgpc_pkg::REG_GAIN_A1_DT: g_a1_next = pwdata[GW-1:0];
                bgpc_pkg::REG_GAIN_R1:    g_r1_next = pwdata[GW-1:0];
                bgpc_pkg::REG_GAIN_R2:    g_r2_next = pwdata[GW-1:0];
                default:                  g_s_next  = g_s_reg;
            endcase
        end

        // Retire the output word when the sink takes it
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (in_acc) begin
            in_next   = s_axis_tdata;
            busy_next = 1'b1;
            step_next = '0;
        end

        if (busy_reg) begin
            // Accumulate the product left by the previous step
            case (uc.acc_op)
                bgpc_pkg::ACC_LOAD:  acc_next = prod_ext;
                bgpc_pkg::ACC_LOADN: acc_next = -prod_ext;
                bgpc_pkg::ACC_ADD:   acc_next = acc_reg + prod_ext;
                bgpc_pkg::ACC_SUB:   acc_next = acc_reg - prod_ext;
                default:             acc_next = acc_reg;
            endcase

            case (uc.wb)
                bgpc_pkg::WB_IL: integ_l_next = wb_integ;
                bgpc_pkg::WB_IR: integ_r_next = wb_integ;
                bgpc_pkg::WB_YL: yaw_l_next   = wb_yaw;
                bgpc_pkg::WB_YR: yaw_r_next   = wb_yaw;
                default:         acc_next     = acc_next;
            endcase

            case (uc.flow)
                bgpc_pkg::FL_DECIDE: begin
                    mode_next = pursue;
                    if (pursue) begin
                        // Latch this tick's errors and their change
                        el_next     = el_c;
                        er_next     = er_c;
                        dl_next     = dl_c;
                        dr_next     = dr_c;
                        prev_l_next = el_c;
                        prev_r_next = er_c;
                        step_next   = step_reg + 1'b1;
                    end else begin
                        // Reload pursuit state from the measured yaw axes
                        integ_l_next = '0;
                        integ_r_next = '0;
                        prev_l_next  = '0;
                        prev_r_next  = '0;
                        yaw_l_next   = alh;
                        yaw_r_next   = arh;
                        step_next    = uc.target;
                    end
                end
                bgpc_pkg::FL_EMIT: begin
                    // Hold here until the output register frees up
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_user_next  = mode_reg;
                        m_data_next  = {mode_reg ? yaw_r_reg : trh, tlv,
                                        mode_reg ? yaw_l_reg : tlh, tlv};
                        busy_next    = 1'b0;
                    end
                end
                default: step_next = step_reg + 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_s_reg     <= '0;
            g_n_reg     <= '0;
            g_k_reg     <= '0;
            g_h_reg     <= '0;
            g_a1_reg    <= '0;
            g_r1_reg    <= '0;
            g_r2_reg    <= '0;
            mode_reg    <= 1'b0;
            prev_l_reg  <= '0;
            prev_r_reg  <= '0;
            integ_l_reg <= '0;
            integ_r_reg <= '0;
            yaw_l_reg   <= '0;
            yaw_r_reg   <= '0;
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            g_s_reg     <= g_s_next;
            g_n_reg     <= g_n_next;
            g_k_reg     <= g_k_next;
            g_h_reg     <= g_h_next;
            g_a1_reg    <= g_a1_next;
            g_r1_reg    <= g_r1_next;
            g_r2_reg    <= g_r2_next;
            mode_reg    <= mode_next;
            prev_l_reg  <= prev_l_next;
            prev_r_reg  <= prev_r_next;
            integ_l_reg <= integ_l_next;
            integ_r_reg <= integ_r_next;
            yaw_l_reg   <= yaw_l_next;
            yaw_r_reg   <= yaw_r_next;
            busy_reg    <= busy_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        el_reg     <= el_next;
        er_reg     <= er_next;
        dl_reg     <= dl_next;
        dr_reg     <= dr_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

// ===== src/bgpc_checker.sv =====
// Port-level checker for the binocular gaze pursuit controller, bound to the top level.
// Depends on binocular_gaze_pursuit_controller port names only.
module bgpc_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic [63:0]   m_axis_tdata,
    input logic          m_axis_tuser,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready
);

    // A held result keeps its word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // Both pitch commands carry the same left-eye target pitch
    a_vert_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[15:0] == m_axis_tdata[47:32])
        else $error("pitch commands differ");

    // The sequencer takes one word at a time
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // Reset empties the output register and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset state wrong");

endmodule

bind binocular_gaze_pursuit_controller bgpc_checker u_bgpc_checker (.*);
